// ===== sv/tlptb_pkg.sv =====
`default_nettype none

package tlptb_pkg;

	// Result status codes.
	localparam logic [2:0] ST_WRITTEN    = 3'd0;
	localparam logic [2:0] ST_SAME       = 3'd1;
	localparam logic [2:0] ST_CONFLICT   = 3'd2;
	localparam logic [2:0] ST_EXHAUSTED  = 3'd3;
	localparam logic [2:0] ST_MISALIGNED = 3'd4;

	// Table geometry of the short-descriptor format.
	localparam int L1_DEPTH   = 4096;
	localparam int L2_ENTRIES = 256;

	// Controller states, one-hot.
	typedef enum logic [3:0] {
		S_CLEAR  = 4'b0001,
		S_IDLE   = 4'b0010,
		S_LOOKUP = 4'b0100,
		S_CHECK  = 4'b1000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic accept;
		logic lookup;
		logic check;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic lookup_stop;
	} sts_t;

endpackage

`default_nettype wire

// ===== sv/tlptb_ram.sv =====
`default_nettype none

module tlptb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/tlptb_ctrl.sv =====
`default_nettype none

module tlptb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output tlptb_pkg::cmd_t        cmd,
	input  wire tlptb_pkg::sts_t   sts
);

	import tlptb_pkg::*;

	state_t state_q;
	state_t state_d;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				state_d = sts.lookup_stop ? S_IDLE : S_CHECK;
			end
			S_CHECK: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// The clearing pass runs after every reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands to the datapath.
	assign cmd.clear  = (state_q == S_CLEAR);
	assign cmd.accept = (state_q == S_IDLE) && start;
	assign cmd.lookup = (state_q == S_LOOKUP);
	assign cmd.check  = (state_q == S_CHECK);
	assign busy       = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== sv/tlptb_datapath.sv =====
`default_nettype none

module tlptb_datapath #(
	parameter int POOL_TABLES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tlptb_pkg::cmd_t   cmd,
	output tlptb_pkg::sts_t        sts,
	input  wire logic              cfg_we,
	input  wire logic [31:0]       pool_base_address,
	input  wire logic [31:0]       page_address,
	input  wire logic [11:0]       page_flags,
	output logic                   done,
	output logic [2:0]             status,
	output logic [31:0]            first_level_descriptor,
	output logic [31:0]            second_level_descriptor
);

	import tlptb_pkg::*;

	localparam int TW     = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
	localparam int CW     = $clog2(POOL_TABLES + 1);
	localparam int PDEPTH = POOL_TABLES * L2_ENTRIES;
	localparam int PAW    = $clog2(PDEPTH);
	localparam int CLR_N  = (PDEPTH > L1_DEPTH) ? PDEPTH : L1_DEPTH;
	localparam int CLW    = $clog2(CLR_N);

	logic [21:0]    base_q;
	logic [19:0]    addr_q;
	logic [11:0]    flags_q;
	logic           mis_q;
	logic [TW-1:0]  table_q;
	logic [PAW-1:0] pa_q;
	logic [CW-1:0]  count_q;
	logic [CLW-1:0] clr_q;

	logic [TW:0]    l1_rd;
	logic           l1_hit;
	logic           pool_full;
	logic           lookup_stop;
	logic           alloc;
	logic [TW-1:0]  table_sel;
	logic [TW+7:0]  pool_ext;
	logic [PAW-1:0] pool_raddr;
	logic           l1_we;
	logic [11:0]    l1_waddr;
	logic [TW:0]    l1_wdata;
	logic           clr_in_l1;
	logic           clr_in_pool;
	logic [31:0]    pool_rd;
	logic [31:0]    wanted;
	logic           small_page;
	logic           pool_we;
	logic [PAW-1:0] pool_waddr;
	logic [31:0]    pool_wdata;
	logic [21:0]    table_base;

	// Pool base register; the low ten bits are not kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= pool_base_address[31:10];
		end
	end

	// Clearing pass counter, covers both tables.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + CLW'(1);
		end
	end

	assign clr_in_l1      = ({1'b0, clr_q} < (CLW + 1)'(L1_DEPTH));
	assign clr_in_pool    = ({1'b0, clr_q} < (CLW + 1)'(PDEPTH));
	assign sts.clear_last = (clr_q == CLW'(CLR_N - 1));

	// Request capture on accept.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q  <= page_address[31:12];
			flags_q <= page_flags;
			mis_q   <= |page_address[11:0];
		end
	end

	// First-level lookup; an aligned miss takes a table if the pool has one.
	assign l1_hit      = l1_rd[TW];
	assign pool_full   = (count_q >= CW'(POOL_TABLES));
	assign lookup_stop = mis_q || (!l1_hit && pool_full);
	assign alloc       = cmd.lookup && !lookup_stop && !l1_hit;
	assign table_sel   = l1_hit ? l1_rd[TW-1:0] : count_q[TW-1:0];
	assign pool_ext    = {table_sel, addr_q[7:0]};
	assign pool_raddr  = pool_ext[PAW-1:0];
	assign sts.lookup_stop = lookup_stop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (alloc) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			table_q <= table_sel;
			pa_q    <= pool_raddr;
		end
	end

	// First-level table write port: clearing pass or new table.
	always_comb begin
		if (cmd.clear) begin
			l1_we    = clr_in_l1;
			l1_waddr = clr_q[11:0];
			l1_wdata = '0;
		end else begin
			l1_we    = alloc;
			l1_waddr = addr_q[19:8];
			l1_wdata = {1'b1, count_q[TW-1:0]};
		end
	end

	tlptb_ram #(
		.WIDTH (TW + 1),
		.DEPTH (L1_DEPTH)
	) u_l1_ram (
		.clk   (clk),
		.we    (l1_we),
		.waddr (l1_waddr),
		.wdata (l1_wdata),
		.raddr (page_address[31:20]),
		.rdata (l1_rd)
	);

	// Second-level check: a small page is kept, anything else is overwritten.
	assign wanted     = {addr_q, flags_q};
	assign small_page = pool_rd[1];

	always_comb begin
		if (cmd.clear) begin
			pool_we    = clr_in_pool;
			pool_waddr = clr_q[PAW-1:0];
			pool_wdata = '0;
		end else begin
			pool_we    = cmd.check && !small_page;
			pool_waddr = pa_q;
			pool_wdata = wanted;
		end
	end

	tlptb_ram #(
		.WIDTH (32),
		.DEPTH (PDEPTH)
	) u_pool_ram (
		.clk   (clk),
		.we    (pool_we),
		.waddr (pool_waddr),
		.wdata (pool_wdata),
		.raddr (pool_raddr),
		.rdata (pool_rd)
	);

	assign table_base = base_q + {{(22 - TW){1'b0}}, table_q};

	// Result register, shown for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (cmd.lookup && lookup_stop) || cmd.check;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup && lookup_stop) begin
			status                  <= mis_q ? ST_MISALIGNED : ST_EXHAUSTED;
			first_level_descriptor  <= '0;
			second_level_descriptor <= '0;
		end else if (cmd.check) begin
			first_level_descriptor <= {table_base, 9'd0, 1'b1};
			if (small_page) begin
				status                  <= (pool_rd == wanted) ? ST_SAME : ST_CONFLICT;
				second_level_descriptor <= pool_rd;
			end else begin
				status                  <= ST_WRITTEN;
				second_level_descriptor <= wanted;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/two_level_page_table_builder.sv =====
// Identity page table builder. Each start transfer maps one 4 KB small page and
// returns one result, shown on the result ports for exactly one cycle while done
// is high; the receiver cannot stall, so results must be taken as they come.
// After reset the block clears both tables in a pass over max(4096, POOL_TABLES*256)
// table addresses, with busy high; configuration writes are taken during that pass.
// Each request then runs through accept, first-level read, and second-level read
// and write, in that order, as the two synchronous table memories are read in
// series. A new start is taken in the cycle done is high. Misaligned addresses
// and an exhausted pool end after the first-level read, with no second-level
// read or write.
// The pool base register should be written only while the block is idle.
`default_nettype none

module two_level_page_table_builder #(
	parameter int POOL_TABLES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] pool_base_address,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] page_address,
	input  wire logic [11:0] page_flags,
	output logic             done,
	output logic [2:0]       status,
	output logic [31:0]      first_level_descriptor,
	output logic [31:0]      second_level_descriptor
);

	import tlptb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The register accepts a transfer in every cycle.
	assign cfg_ready = 1'b1;

	tlptb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	tlptb_datapath #(
		.POOL_TABLES (POOL_TABLES)
	) u_datapath (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.cmd                     (cmd),
		.sts                     (sts),
		.cfg_we                  (cfg_valid && cfg_ready),
		.pool_base_address       (pool_base_address),
		.page_address            (page_address),
		.page_flags              (page_flags),
		.done                    (done),
		.status                  (status),
		.first_level_descriptor  (first_level_descriptor),
		.second_level_descriptor (second_level_descriptor)
	);

endmodule

`default_nettype wire
